@@ hw/rtl/rtc_snapshot_to_epoch_unit_macros.svh @@
// ----------------------------------------------------------------------------
// RTC snapshot to epoch unit: assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RTC_SNAPSHOT_TO_EPOCH_UNIT_MACROS_SVH
`define RTC_SNAPSHOT_TO_EPOCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSE_ASSERT_IMP(lbl, ante, cons, msg)
`define RSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// RSE package
// Types, constants and small decode functions of the RTC snapshot to epoch unit.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpAW   = 26;  // multiplicand of the shared unit
  localparam int unsigned OpBW   = 19;  // multiplier of the shared unit
  localparam int unsigned AccW   = 42;  // addend and result
  localparam int unsigned EpochW = 41;

  // status B bits
  localparam logic [ByteW-1:0] StatB24Hour   = 8'h02;
  localparam logic [ByteW-1:0] StatBBinary   = 8'h04;
  localparam logic [ByteW-1:0] HourPmMask    = 8'h80;
  localparam logic [ByteW-1:0] HourValueMask = 8'h7F;
  localparam logic [3:0]       NibbleMask    = 4'hF;

  localparam logic [3:0] MonthsPerYear = 4'd12;
  localparam logic [3:0] HalfDayHours  = 4'd12;

  // multiply-add coefficients
  localparam logic signed [OpBW-1:0] MulCentury = OpBW'(100);
  localparam logic signed [OpBW-1:0] MulRecip12 = OpBW'(171);   // 2^11 / 12, rounded up
  localparam logic signed [OpBW-1:0] MulNeg12   = OpBW'(-12);
  localparam logic signed [OpBW-1:0] MulOne     = OpBW'(1);
  localparam logic signed [OpBW-1:0] MulRcp400  = OpBW'(5243);  // 2^21 / 400, rounded up
  localparam logic signed [OpBW-1:0] MulNeg400  = OpBW'(-400);
  localparam logic signed [OpBW-1:0] MulYear    = OpBW'(365);
  localparam logic signed [OpBW-1:0] MulEra     = OpBW'(146097);
  localparam logic signed [OpBW-1:0] MulMinute  = OpBW'(60);
  localparam logic signed [OpBW-1:0] MulHour    = OpBW'(3600);
  localparam logic signed [OpBW-1:0] MulDay     = OpBW'(86400);

  localparam int unsigned Recip12Shift = 11;
  localparam int unsigned Rcp400Shift  = 21;

  // year offset keeps the shifted year positive; one era is taken back in DaysBias
  localparam logic [15:0] YearBias = 16'd400;
  // day - 1, epoch day of 0000-03-01, one era of YearBias
  localparam logic [19:0] DaysBias = 20'd865566;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MDIV,
    ST_MREM,
    ST_YADJ,
    ST_EDIV,
    ST_EREM,
    ST_DOE,
    ST_DAYS,
    ST_TMIN,
    ST_THR,
    ST_TOT,
    ST_DONE
  } rse_state_e;

  typedef struct packed {
    logic [ByteW-1:0] sec;
    logic [ByteW-1:0] min;
    logic [ByteW-1:0] hr;
    logic [ByteW-1:0] day;
    logic [ByteW-1:0] mon;
    logic [ByteW-1:0] yr;
    logic [ByteW-1:0] cen;
  } rse_fields_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rse_status_t;

  // nibbles above 9 still weigh high*10 + low
  function automatic logic [ByteW-1:0] bcd_dec(input logic [ByteW-1:0] b);
    return ByteW'(b[7:4]) * ByteW'(10) + ByteW'(b[3:0] & NibbleMask);
  endfunction

  // value mod 12 for values below 128
  function automatic logic [3:0] hour_mod12(input logic [6:0] h);
    logic [6:0] v;
    v = h;
    if (v >= 7'd96) v = v - 7'd96;
    if (v >= 7'd48) v = v - 7'd48;
    if (v >= 7'd24) v = v - 7'd24;
    if (v >= 7'd12) v = v - 7'd12;
    return v[3:0];
  endfunction

  // days from March 1st to the first of the month; index 0 is January
  function automatic logic [8:0] month_doy(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd306;  // January, counted in the year before
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // year of era / 100 for year of era below 400
  function automatic logic [1:0] centuries(input logic [8:0] yoe);
    logic [1:0] c;
    priority if (yoe >= 9'd300) c = 2'd3;
    else if (yoe >= 9'd200)     c = 2'd2;
    else if (yoe >= 9'd100)     c = 2'd1;
    else                        c = 2'd0;
    return c;
  endfunction

endpackage

@@ hw/rtl/rse_muladd.sv @@
// ----------------------------------------------------------------------------
// RSE multiply-add
// Shared signed unit r = c + a * b, used once per sequencer step.
// ----------------------------------------------------------------------------
module rse_muladd
  import rse_pkg::*;
(
  input  logic signed [OpAW-1:0] a_i,
  input  logic signed [OpBW-1:0] b_i,
  input  logic signed [AccW-1:0] c_i,
  output logic signed [AccW-1:0] r_o
);

  logic signed [OpAW+OpBW-1:0] prod;

  assign prod = a_i * b_i;
  assign r_o  = c_i + AccW'(prod);

endmodule

@@ hw/rtl/rse_core.sv @@
// ----------------------------------------------------------------------------
// RSE core
// Sequencer that turns decoded date fields into epoch seconds on the shared
// multiply-add unit, one step per cycle.
// ----------------------------------------------------------------------------
`include "rtc_snapshot_to_epoch_unit_macros.svh"

module rse_core
  import rse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rse_fields_t         fields_i,
  input  logic                out_free_i,
  output rse_status_t         status_o,
  output logic [EpochW-1:0]   result_o
);

  rse_state_e state_q, state_d;

  rse_fields_t              fld_q;
  logic [15:0]              year0_q;
  logic signed [5:0]        yadd_q;
  logic [3:0]               midx_q;
  logic [14:0]              yp_q;
  logic [6:0]               era_q;
  logic [8:0]               yoe_q;
  logic [17:0]              doe_q;
  logic signed [24:0]       days_q;
  logic [18:0]              t_q;
  logic [EpochW-1:0]        res_q;

  logic signed [OpAW-1:0]   op_a;
  logic signed [OpBW-1:0]   op_b;
  logic signed [AccW-1:0]   op_c;
  logic signed [AccW-1:0]   mul_r;
  logic signed [8:0]        mon0;
  logic                     le2;

  assign mon0 = $signed({1'b0, fld_q.mon}) - 9'sd1;
  assign le2  = (midx_q < 4'd2);

  rse_muladd u_muladd (
    .a_i (op_a),
    .b_i (op_b),
    .c_i (op_c),
    .r_o (mul_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_a    = '0;
    op_b    = '0;
    op_c    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_YEAR;
      end
      ST_YEAR: begin
        op_a    = OpAW'(fld_q.cen);
        op_b    = MulCentury;
        op_c    = AccW'(fld_q.yr);
        state_d = ST_MDIV;
      end
      ST_MDIV: begin
        op_a    = OpAW'(mon0);
        op_b    = MulRecip12;
        state_d = ST_MREM;
      end
      ST_MREM: begin
        op_a    = OpAW'(yadd_q);
        op_b    = MulNeg12;
        op_c    = AccW'(mon0);
        state_d = ST_YADJ;
      end
      ST_YADJ: begin
        // January and February count in the year before
        op_a    = OpAW'(yadd_q);
        op_b    = MulOne;
        op_c    = AccW'(year0_q) + AccW'(YearBias) - AccW'(le2);
        state_d = ST_EDIV;
      end
      ST_EDIV: begin
        op_a    = OpAW'(yp_q);
        op_b    = MulRcp400;
        state_d = ST_EREM;
      end
      ST_EREM: begin
        op_a    = OpAW'(era_q);
        op_b    = MulNeg400;
        op_c    = AccW'(yp_q);
        state_d = ST_DOE;
      end
      ST_DOE: begin
        op_a    = OpAW'(yoe_q);
        op_b    = MulYear;
        op_c    = AccW'(month_doy(midx_q)) + AccW'(yoe_q[8:2]) - AccW'(centuries(yoe_q));
        state_d = ST_DAYS;
      end
      ST_DAYS: begin
        op_a    = OpAW'(era_q);
        op_b    = MulEra;
        op_c    = AccW'(doe_q) + AccW'(fld_q.day) - AccW'(DaysBias);
        state_d = ST_TMIN;
      end
      ST_TMIN: begin
        op_a    = OpAW'(fld_q.min);
        op_b    = MulMinute;
        op_c    = AccW'(fld_q.sec);
        state_d = ST_THR;
      end
      ST_THR: begin
        op_a    = OpAW'(fld_q.hr);
        op_b    = MulHour;
        op_c    = AccW'(t_q);
        state_d = ST_TOT;
      end
      ST_TOT: begin
        op_a    = OpAW'(days_q);
        op_b    = MulDay;
        op_c    = AccW'(t_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (start_i) fld_q <= fields_i;
      ST_YEAR: year0_q <= mul_r[15:0];
      ST_MDIV: begin
        if (fld_q.mon == '0) begin
          yadd_q <= '1;  // month zero: December of the year before
        end else begin
          yadd_q <= $signed({1'b0, mul_r[Recip12Shift+4:Recip12Shift]});
        end
      end
      ST_MREM: midx_q <= mul_r[3:0];
      ST_YADJ: yp_q   <= mul_r[14:0];
      ST_EDIV: era_q  <= mul_r[Rcp400Shift+6:Rcp400Shift];
      ST_EREM: yoe_q  <= mul_r[8:0];
      ST_DOE:  doe_q  <= mul_r[17:0];
      ST_DAYS: days_q <= mul_r[24:0];
      ST_TMIN: t_q    <= mul_r[18:0];
      ST_THR:  t_q    <= mul_r[18:0];
      ST_TOT:  res_q  <= mul_r[EpochW-1:0];
      default: ;
    endcase
  end

  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);
  assign result_o      = res_q;

  `RSE_ASSERT_NXT(a_start_seq, (state_q == ST_IDLE) && start_i, state_q == ST_YEAR, "start lost")
  `RSE_ASSERT_NXT(a_midx_range, state_q == ST_MREM, midx_q < MonthsPerYear, "month index range")
  `RSE_ASSERT_NXT(a_yoe_range, state_q == ST_EREM, yoe_q < 9'd400, "year of era range")
  `RSE_ASSERT_NXT(a_done_hold, (state_q == ST_DONE) && !out_free_i, (state_q == ST_DONE) && $stable(res_q), "result dropped")

endmodule

@@ hw/rtl/rtc_snapshot_to_epoch_unit.sv @@
// ----------------------------------------------------------------------------
// RTC snapshot to epoch unit
// Stable-read filter on raw RTC bytes and conversion to Unix epoch seconds.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw RTC snapshot. A result comes out only
// when the snapshot equals the one taken by the previous transaction (never for
// the first after reset). A snapshot that yields no result is accepted and the
// next can follow at once. A matching snapshot occupies the core, in_stall_o
// high, until its epoch value is loaded into the output register; the single
// shared multiply-add unit is stepped by the sequencer through eleven date and
// time terms, one per cycle, and the core then waits in its done state until
// the output register is free. A waiting result does not stall input unless
// the next matching snapshot finishes before it is taken.
`include "rtc_snapshot_to_epoch_unit_macros.svh"

module rtc_snapshot_to_epoch_unit
  import rse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         raw_seconds_i,
  input  logic [ByteW-1:0]         raw_minutes_i,
  input  logic [ByteW-1:0]         raw_hours_i,
  input  logic [ByteW-1:0]         raw_day_i,
  input  logic [ByteW-1:0]         raw_month_i,
  input  logic [ByteW-1:0]         raw_year_i,
  input  logic [ByteW-1:0]         raw_century_i,
  input  logic [ByteW-1:0]         raw_status_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [EpochW-1:0] epoch_seconds_o
);

  logic [8*ByteW-1:0] snap;
  logic [8*ByteW-1:0] prev_q;
  logic               prev_valid_q;
  logic               in_accept;
  logic               core_start;
  logic               out_free;
  logic               out_valid_q;
  logic [EpochW-1:0]  epoch_q;
  logic [EpochW-1:0]  core_res;
  rse_status_t        status;
  rse_fields_t        fields;

  logic               bin_mode;
  logic               hour12;
  logic               pm;
  logic [ByteW-1:0]   hr_raw;
  logic [ByteW-1:0]   hr_dec;

  assign snap = {raw_status_i, raw_century_i, raw_year_i, raw_month_i,
                 raw_day_i, raw_hours_i, raw_minutes_i, raw_seconds_i};

  assign in_stall_o = status.busy;
  assign in_accept  = in_valid_i && !status.busy;
  assign core_start = in_accept && prev_valid_q && (snap == prev_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // field decode
  assign bin_mode = (raw_status_i & StatBBinary) != '0;
  assign hour12   = (raw_status_i & StatB24Hour) == '0;
  assign pm       = hour12 && ((raw_hours_i & HourPmMask) != '0);
  assign hr_raw   = raw_hours_i & HourValueMask;
  assign hr_dec   = bin_mode ? hr_raw : bcd_dec(hr_raw);

  always_comb begin
    fields.sec = bin_mode ? raw_seconds_i : bcd_dec(raw_seconds_i);
    fields.min = bin_mode ? raw_minutes_i : bcd_dec(raw_minutes_i);
    fields.day = bin_mode ? raw_day_i     : bcd_dec(raw_day_i);
    fields.mon = bin_mode ? raw_month_i   : bcd_dec(raw_month_i);
    fields.yr  = bin_mode ? raw_year_i    : bcd_dec(raw_year_i);
    fields.cen = bin_mode ? raw_century_i : bcd_dec(raw_century_i);
    if (hour12) begin
      // 12 AM is hour 0, 12 PM is hour 12
      fields.hr = ByteW'(hour_mod12(hr_dec[6:0])) + (pm ? ByteW'(HalfDayHours) : '0);
    end else begin
      fields.hr = hr_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
    end else if (in_accept) begin
      prev_q       <= snap;
      prev_valid_q <= 1'b1;
    end
  end

  rse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (core_start),
    .fields_i   (fields),
    .out_free_i (out_free),
    .status_o   (status),
    .result_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (status.done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done && out_free) epoch_q <= core_res;
  end

  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = $signed(epoch_q);

  `RSE_ASSERT_NXT(a_prev_load, in_accept, prev_valid_q && (prev_q == $past(snap)), "snapshot not kept")
  `RSE_ASSERT_NXT(a_match_start, core_start, status.busy, "matching snapshot not started")
  `RSE_ASSERT_NXT(a_out_load, status.done && out_free, out_valid_q && (epoch_q == $past(core_res)), "result not loaded")

endmodule
